// ----- src/kfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keepalive fault monitor package
// Event, action, mode and register codes shared by the monitor's modules.
// ----------------------------------------------------------------------------
package kfm_pkg;

  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 31;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef logic [1:0]         op_t;
  typedef logic [1:0]         action_t;
  typedef logic [1:0]         mode_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_REQUEST = 2'd1;
  localparam op_t OP_ACK     = 2'd2;

  localparam action_t ACT_NONE    = 2'd0;
  localparam action_t ACT_CLEARED = 2'd1;
  localparam action_t ACT_REPORT  = 2'd2;
  localparam action_t ACT_DEACT   = 2'd3;

  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_FAULT  = 2'd1;
  localparam mode_t MODE_AWAIT  = 2'd2;

  localparam logic [1:0] REG_IDLE_TIMEOUT     = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT      = 2'd1;
  localparam logic [1:0] REG_DEACTIVATE_DELAY = 2'd2;
  localparam logic [1:0] REG_ALLOW_DEACTIVATE = 2'd3;

  localparam limit_t RST_TIMEOUT = 31'd1000;

  typedef struct packed {
    limit_t idle_timeout;
    limit_t ack_timeout;
    limit_t deactivate_delay;
    logic   allow_deactivate;
  } cfg_t;

endpackage

// ----- src/kfm_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keepalive fault monitor channels
// Event channel (op, timestamp) and action channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kfm_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_time;

  modport source (output valid, output op, output now_time, input ready);
  modport sink   (input valid, input op, input now_time, output ready);
endinterface

interface kfm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;

  modport source (output valid, output action, input ready);
  modport sink   (input valid, input action, output ready);
endinterface

// ----- src/kfm_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keepalive fault monitor configuration registers
// APB-style register file holding the three timeouts and the allow flag.
// ----------------------------------------------------------------------------
module kfm_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kfm_pkg::ADDR_W-1:0] paddr,
  input  logic [kfm_pkg::DATA_W-1:0] pwdata,
  output logic [kfm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output kfm_pkg::cfg_t              cfg
);
  import kfm_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_timeout     <= RST_TIMEOUT;
      cfg.ack_timeout      <= RST_TIMEOUT;
      cfg.deactivate_delay <= RST_TIMEOUT;
      cfg.allow_deactivate <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_IDLE_TIMEOUT:     cfg.idle_timeout     <= pwdata[LIMIT_W-1:0];
        REG_ACK_TIMEOUT:      cfg.ack_timeout      <= pwdata[LIMIT_W-1:0];
        REG_DEACTIVATE_DELAY: cfg.deactivate_delay <= pwdata[LIMIT_W-1:0];
        REG_ALLOW_DEACTIVATE: cfg.allow_deactivate <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IDLE_TIMEOUT:     prdata = {1'b0, cfg.idle_timeout};
      REG_ACK_TIMEOUT:      prdata = {1'b0, cfg.ack_timeout};
      REG_DEACTIVATE_DELAY: prdata = {1'b0, cfg.deactivate_delay};
      REG_ALLOW_DEACTIVATE: prdata = {{(DATA_W-1){1'b0}}, cfg.allow_deactivate};
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- src/kfm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keepalive fault monitor core
// Input register, watchdog state update with one elapsed-time compare, and
// action result register.
// ----------------------------------------------------------------------------
module kfm_core (
  input  logic          clk,
  input  logic          rst,
  input  kfm_pkg::cfg_t cfg,
  kfm_evt_if.sink       evt,
  kfm_res_if.source     res
);
  import kfm_pkg::*;

  logic    s1_valid;
  op_t     s1_op;
  time_t   s1_now;
  logic    adv;

  mode_t   mode, mode_next;
  logic    started, started_next;
  time_t   last_request_time, last_request_time_next;
  time_t   fault_time, fault_time_next;
  time_t   ack_time, ack_time_next;
  action_t act_next;

  logic    res_valid;
  action_t res_action;

  time_t   since;
  limit_t  limit;
  time_t   elapsed;
  logic    expired;

  assign adv       = !res_valid || res.ready;
  assign evt.ready = !s1_valid || adv;
  assign res.valid  = res_valid;
  assign res.action = res_action;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_op  <= evt.op;
      s1_now <= evt.now_time;
    end
  end

  // Pick the timestamp and limit for the current mode.
  always_comb begin
    case (mode)
      MODE_FAULT: begin
        since = fault_time;
        limit = cfg.ack_timeout;
      end
      MODE_AWAIT: begin
        since = ack_time;
        limit = cfg.deactivate_delay;
      end
      default: begin
        since = last_request_time;
        limit = cfg.idle_timeout;
      end
    endcase
    elapsed = s1_now - since;
    expired = elapsed >= {1'b0, limit};
  end

  always_comb begin
    mode_next              = mode;
    started_next           = started;
    last_request_time_next = last_request_time;
    fault_time_next        = fault_time;
    ack_time_next          = ack_time;
    act_next               = ACT_NONE;
    case (s1_op)
      OP_TICK: begin
        if (!started) begin
          last_request_time_next = s1_now;
          started_next           = 1'b1;
        end else begin
          case (mode)
            MODE_NORMAL: begin
              if (expired) begin
                mode_next       = MODE_FAULT;
                fault_time_next = s1_now;
                act_next        = ACT_REPORT;
              end
            end
            MODE_FAULT: begin
              if (expired) begin
                mode_next              = MODE_NORMAL;
                last_request_time_next = s1_now;
                act_next               = cfg.allow_deactivate ? ACT_DEACT : ACT_NONE;
              end
            end
            MODE_AWAIT: begin
              if (expired) begin
                mode_next              = MODE_NORMAL;
                last_request_time_next = s1_now;
                act_next               = ACT_DEACT;
              end
            end
            default: ;
          endcase
        end
      end
      OP_REQUEST: begin
        last_request_time_next = s1_now;
        started_next           = 1'b1;
        if (mode != MODE_NORMAL) begin
          mode_next = MODE_NORMAL;
          act_next  = ACT_CLEARED;
        end
      end
      OP_ACK: begin
        if (mode == MODE_FAULT) begin
          if (cfg.allow_deactivate) begin
            mode_next     = MODE_AWAIT;
            ack_time_next = s1_now;
          end else begin
            mode_next              = MODE_NORMAL;
            last_request_time_next = s1_now;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_NORMAL;
      started           <= 1'b0;
      last_request_time <= '0;
      fault_time        <= '0;
      ack_time          <= '0;
    end else if (s1_valid && adv) begin
      mode              <= mode_next;
      started           <= started_next;
      last_request_time <= last_request_time_next;
      fault_time        <= fault_time_next;
      ack_time          <= ack_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      res_action <= act_next;
    end
  end

endmodule

// ----- src/keepalive_fault_monitor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keepalive fault monitor
// Watchdog over keepalive events that raises, clears and escalates faults.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one event per transfer: op (tick, request seen, fault report
//   acknowledged) and the 32-bit timestamp now_time. res returns exactly one
//   action per event, in order: none, fault cleared, fault report, or
//   deactivate all tasks.
//   Path: input register, then state update and compare into result register.
//   One event is taken per cycle while res is not stalled; the single
//   elapsed-time subtract and compare against the stored timestamp sets the
//   cycle. When res is stalled, the result register holds and the input
//   register still takes one more event; evt.ready then drops until res moves.
//   Reset (rst, synchronous) clears both pipeline stages, returns the monitor
//   to normal mode and not started, and loads all timeouts with 1000 and
//   the allow flag with 0. The user must have the APB port write the
//   registers only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module keepalive_fault_monitor_top (
  input  logic                       clk,
  input  logic                       rst,
  kfm_evt_if.sink                    evt,
  kfm_res_if.source                  res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kfm_pkg::ADDR_W-1:0] paddr,
  input  logic [kfm_pkg::DATA_W-1:0] pwdata,
  output logic [kfm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import kfm_pkg::*;

  cfg_t cfg;

  kfm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kfm_core u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .evt (evt),
    .res (res)
  );

endmodule

// ----- verif/tb_keepalive_fault_monitor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keepalive fault monitor testbench
// Drives tick, request and acknowledge events with wrapping timestamps into
// the monitor, rewrites the timeouts and the allow flag over APB between
// phases, and checks every returned action in order against a cycle-free
// model of the watchdog held in a small scoreboard. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_keepalive_fault_monitor_top;
  import kfm_pkg::*;

  localparam op_t OP_UNUSED     = 2'd3;
  localparam int  PHASES        = 8;
  localparam int  PHASE_EVENTS  = 116;
  localparam int  STALL_LIMIT   = 2000;
  localparam limit_t LIMIT_MAX  = 31'h7FFF_FFFF;

  typedef struct {
    action_t act;
    op_t     op;
    time_t   stamp;
  } expected_t;

  class action_scoreboard;
    limit_t      idle_limit;
    limit_t      ack_limit;
    limit_t      deact_limit;
    bit          allow_deact;
    mode_t       mode;
    bit          started;
    time_t       last_request;
    time_t       fault_stamp;
    time_t       ack_stamp;
    expected_t   pending[$];
    int          errors;

    function new();
      idle_limit   = RST_TIMEOUT;
      ack_limit    = RST_TIMEOUT;
      deact_limit  = RST_TIMEOUT;
      allow_deact  = 1'b0;
      mode         = MODE_NORMAL;
      started      = 1'b0;
      last_request = '0;
      fault_stamp  = '0;
      ack_stamp    = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [1:0] idx, limit_t value);
      case (idx)
        REG_IDLE_TIMEOUT:     idle_limit  = value;
        REG_ACK_TIMEOUT:      ack_limit   = value;
        REG_DEACTIVATE_DELAY: deact_limit = value;
        REG_ALLOW_DEACTIVATE: allow_deact = value[0];
        default: ;
      endcase
    endfunction

    function bit expired(time_t stamp_now, time_t since, limit_t lim);
      time_t span;
      span = stamp_now - since;
      return span >= {1'b0, lim};
    endfunction

    function action_t predict_action(op_t op, time_t t);
      action_t act;
      act = ACT_NONE;
      case (op)
        OP_TICK: begin
          if (!started) begin
            last_request = t;
            started      = 1'b1;
          end else if (mode == MODE_NORMAL) begin
            if (expired(t, last_request, idle_limit)) begin
              mode        = MODE_FAULT;
              fault_stamp = t;
              act         = ACT_REPORT;
            end
          end else if (mode == MODE_FAULT) begin
            if (expired(t, fault_stamp, ack_limit)) begin
              mode         = MODE_NORMAL;
              last_request = t;
              act          = allow_deact ? ACT_DEACT : ACT_NONE;
            end
          end else if (mode == MODE_AWAIT) begin
            if (expired(t, ack_stamp, deact_limit)) begin
              mode         = MODE_NORMAL;
              last_request = t;
              act          = ACT_DEACT;
            end
          end
        end
        OP_REQUEST: begin
          last_request = t;
          started      = 1'b1;
          if (mode != MODE_NORMAL) begin
            mode = MODE_NORMAL;
            act  = ACT_CLEARED;
          end
        end
        OP_ACK: begin
          if (mode == MODE_FAULT) begin
            if (allow_deact) begin
              mode      = MODE_AWAIT;
              ack_stamp = t;
            end else begin
              mode         = MODE_NORMAL;
              last_request = t;
            end
          end
        end
        default: ;
      endcase
      return act;
    endfunction

    function void note_event(op_t op, time_t t);
      expected_t item;
      item.op    = op;
      item.stamp = t;
      item.act   = predict_action(op, t);
      pending = {pending, item};
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_action(action_t got);
      expected_t exp_item;
      if (pending.size() == 0) begin
        report($sformatf("action %0d with no event outstanding", got));
        return;
      end
      exp_item = pending.pop_front();
      if (got !== exp_item.act)
        report($sformatf("op %0d at %h: action %0d, predicted %0d",
                         exp_item.op, exp_item.stamp, got, exp_item.act));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  kfm_evt_if evt_ch ();
  kfm_res_if res_ch ();

  action_scoreboard sb = new();

  bit src_eager;
  bit sink_eager;
  int stall_left;
  int quiet_cycles;

  keepalive_fault_monitor_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function time_t next_stamp(time_t cur);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return cur;
    if (r < 75) return cur + $urandom_range(1, 60);
    if (r < 85) return cur + 32'h7FFF_FFFF + $urandom_range(0, 2) - 1;
    if (r < 95) return $urandom;
    return cur + $urandom_range(1, 2000);
  endfunction

  function op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_UNUSED;
    if (sb.mode == MODE_FAULT) begin
      if (r < 50) return OP_ACK;
      if (r < 65) return OP_REQUEST;
      return OP_TICK;
    end
    if (r < 15) return OP_ACK;
    if (r < (sb.mode == MODE_AWAIT ? 40 : 30)) return OP_REQUEST;
    return OP_TICK;
  endfunction

  function limit_t pick_limit();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 31'd1;
    if (r == 1) return LIMIT_MAX;
    return limit_t'($urandom_range(1, 40));
  endfunction

  task apb_write(logic [1:0] idx, limit_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {1'b0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task configure(limit_t idle, limit_t ack, limit_t deact, bit allow);
    apb_write(REG_IDLE_TIMEOUT, idle);
    apb_write(REG_ACK_TIMEOUT, ack);
    apb_write(REG_DEACTIVATE_DELAY, deact);
    apb_write(REG_ALLOW_DEACTIVATE, {30'd0, allow});
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task send_event(op_t op, time_t t);
    int gap;
    gap = src_eager ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      evt_ch.valid = 1'b0;
    end
    @(negedge clk);
    evt_ch.valid    = 1'b1;
    evt_ch.op       = op;
    evt_ch.now_time = t;
    do @(posedge clk); while (!evt_ch.ready);
    sb.note_event(op, t);
  endtask

  // result side: random stalls, eager stretches per phase
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready = 1'b0;
      stall_left--;
    end else begin
      res_ch.ready = 1'b1;
      if (!sink_eager && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_action(res_ch.action);
  end

  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    time_t stamp;
    int    phase;
    int    n;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    evt_ch.valid    = 1'b0;
    evt_ch.op       = OP_TICK;
    evt_ch.now_time = '0;
    res_ch.ready    = 1'b0;
    stall_left      = 0;
    quiet_cycles    = 0;
    src_eager       = 1'b0;
    sink_eager      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset timeouts of 1000, deactivation not allowed
    send_event(OP_UNUSED,  32'd0);
    send_event(OP_ACK,     32'd5);
    send_event(OP_TICK,    32'd100);
    send_event(OP_TICK,    32'd1099);
    send_event(OP_TICK,    32'd1100);
    send_event(OP_REQUEST, 32'd1200);
    send_event(OP_REQUEST, 32'd1300);
    send_event(OP_TICK,    32'd2300);
    send_event(OP_ACK,     32'd2400);
    send_event(OP_TICK,    32'd3399);
    send_event(OP_TICK,    32'd3400);
    send_event(OP_TICK,    32'd4399);
    send_event(OP_TICK,    32'd4400);
    send_event(OP_TICK,    32'hFFFF_FFF0);
    send_event(OP_UNUSED,  32'h0000_0000);
    send_event(OP_TICK,    32'h0000_03D8);
    send_event(OP_TICK,    32'hAAAA_5555);
    send_event(OP_ACK,     32'h5555_AAAA);

    stamp = $urandom;
    for (phase = 0; phase < PHASES; phase++) begin
      @(negedge clk);
      evt_ch.valid = 1'b0;
      wait_drained();
      case (phase)
        0: configure(31'd1, 31'd1, 31'd1, 1'b1);
        1: configure(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1'b0);
        2: configure(LIMIT_MAX, 31'd1, LIMIT_MAX, 1'b1);
        default: configure(pick_limit(), pick_limit(), pick_limit(),
                           bit'($urandom_range(0, 1)));
      endcase
      src_eager  = (phase % 3 == 1);
      sink_eager = (phase % 4 == 2);
      for (n = 0; n < PHASE_EVENTS; n++) begin
        stamp = next_stamp(stamp);
        send_event(pick_op(), stamp);
      end
    end

    @(negedge clk);
    evt_ch.valid = 1'b0;
    wait_drained();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
